### rtl/mva_pkg.sv
// Shared types and constants for the 3x3 matrix and vector arithmetic unit.
// Holds the command and result structs, the control structs between the
// sequencer and the datapath, and the element addressing helpers. No dependencies.
package mva_pkg;

    // Fixed field widths of the command and result transfers.
    localparam int unsigned FIELD_W = 32;
    // Width of one multiplier digit; products are built a digit at a time.
    localparam int unsigned DIG_W   = 16;
    // Elements in one 3x3 matrix.
    localparam int unsigned ELEMS   = 9;

    typedef enum logic [2:0] {
        MODE_LOAD_A  = 3'd0,
        MODE_LOAD_B  = 3'd1,
        MODE_MAT_ADD = 3'd2,
        MODE_VEC_ADD = 3'd3,
        MODE_MAT_MUL = 3'd4,
        MODE_MAT_VEC = 3'd5,
        MODE_DOT     = 3'd6,
        MODE_CROSS   = 3'd7
    } mode_t;

    // Source of the second multiplier operand.
    typedef enum logic [1:0] {
        Q_ONE = 2'd0,
        Q_A1  = 2'd1,
        Q_B   = 2'd2
    } qsel_t;

    typedef struct packed {
        mode_t                      mode;
        logic [1:0]                 row_index;
        logic [1:0]                 col_index;
        logic signed [FIELD_W-1:0]  element_value;
    } cmd_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0]  result_value;
        logic [1:0]                 out_row;
        logic [1:0]                 out_col;
        logic                       last_result;
    } res_t;

    typedef struct packed {
        logic       a_we;
        logic       b_we;
        logic [3:0] waddr;
        logic       re;
        logic [3:0] a_raddr0;
        logic [3:0] a_raddr1;
        logic [3:0] b_raddr;
    } mem_ctrl_t;

    typedef struct packed {
        logic   mul_en;
        logic   acc_en;
        logic   first;
        logic   negate;
        logic   p_sel_b;
        qsel_t  q_sel;
    } mac_ctrl_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic [1:0] col;
        logic       last;
    } emit_t;

    // Row-major element address: row * 3 + col.
    function automatic logic [3:0] elem_addr(input logic [1:0] r, input logic [1:0] c);
        elem_addr = {2'b00, r} + {1'b0, r, 1'b0} + {2'b00, c};
    endfunction

    // Next index modulo three.
    function automatic logic [1:0] next3(input logic [1:0] i);
        next3 = (i == 2'd2) ? 2'd0 : i + 2'd1;
    endfunction

    // Index of the final product term of one result.
    function automatic logic [1:0] last_term(input mode_t m);
        case (m)
            MODE_MAT_ADD, MODE_VEC_ADD, MODE_CROSS: last_term = 2'd1;
            default:                                last_term = 2'd2;
        endcase
    endfunction

endpackage

### rtl/mva_mem.sv
// Nine-entry matrix store with one write port and registered read ports.
// Read data is registered, appearing in the cycle after the read enable, and holds otherwise.
// Uses mva_pkg for the entry count.
module mva_mem #(
    parameter int W        = 32,
    parameter int RD_PORTS = 1
) (
    input  logic                               clk,
    input  logic                               we,
    input  logic [3:0]                         waddr,
    input  logic [W-1:0]                       wdata,
    input  logic                               re,
    input  logic [RD_PORTS-1:0][3:0]           raddr,
    output logic [RD_PORTS-1:0][W-1:0]         rdata
);

    logic [W-1:0] mem [0:mva_pkg::ELEMS-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            for (int p = 0; p < RD_PORTS; p++)
            begin
                rdata[p] <= mem[raddr[p]];
            end
        end
    end

endmodule

### rtl/mva_mac.sv
// Shared multiply-accumulate datapath: one operand times one digit of the other
// per step, the product registered, then shifted into the running sum.
// Uses mva_pkg for the control struct and digit width.
module mva_mac #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  mva_pkg::mac_ctrl_t     ctrl,
    input  logic [((((DATA_WIDTH + mva_pkg::DIG_W - 1) / mva_pkg::DIG_W) > 1) ?
                   $clog2((DATA_WIDTH + mva_pkg::DIG_W - 1) / mva_pkg::DIG_W) : 1) - 1:0]
                                   digit,
    input  logic [DATA_WIDTH-1:0]  a_rd0,
    input  logic [DATA_WIDTH-1:0]  a_rd1,
    input  logic [DATA_WIDTH-1:0]  b_rd,
    output logic [DATA_WIDTH-1:0]  sum
);

    localparam int NDIG  = (DATA_WIDTH + mva_pkg::DIG_W - 1) / mva_pkg::DIG_W;
    localparam int PAD_W = NDIG * mva_pkg::DIG_W;

    logic [DATA_WIDTH-1:0]     p;
    logic [DATA_WIDTH-1:0]     q;
    logic [PAD_W-1:0]          q_pad;
    logic [mva_pkg::DIG_W-1:0] q_dig;
    logic [DATA_WIDTH-1:0]     prod_reg;
    logic [DATA_WIDTH-1:0]     shifted;
    logic [DATA_WIDTH-1:0]     addend;
    logic [DATA_WIDTH-1:0]     acc_reg;
    logic [DATA_WIDTH-1:0]     acc_next;

    always_comb
    begin
        p = ctrl.p_sel_b ? b_rd : a_rd0;
        case (ctrl.q_sel)
            mva_pkg::Q_ONE: q = DATA_WIDTH'(1);
            mva_pkg::Q_A1:  q = a_rd1;
            mva_pkg::Q_B:   q = b_rd;
            default:        q = b_rd;
        endcase
        q_pad = PAD_W'(q);
        q_dig = q_pad[digit * mva_pkg::DIG_W +: mva_pkg::DIG_W];
    end

    // Only the low DATA_WIDTH bits of any product matter, as all results wrap.
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= DATA_WIDTH'(p * DATA_WIDTH'(q_dig));
        end
    end

    always_comb
    begin
        shifted  = prod_reg << (digit * mva_pkg::DIG_W);
        addend   = ctrl.negate ? DATA_WIDTH'(-shifted) : shifted;
        acc_next = (ctrl.first ? '0 : acc_reg) + addend;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.acc_en)
        begin
            acc_reg <= acc_next;
        end
    end

    assign sum = acc_next;

endmodule

### rtl/mva_seq.sv
// Operation sequencer: takes commands, writes loads into the stores and walks
// results, product terms and multiplier digits for each operation.
// Uses mva_pkg for command, control and addressing definitions.
module mva_seq #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  mva_pkg::cmd_t          cmd,
    output logic                   busy,
    output mva_pkg::mem_ctrl_t     mem,
    output mva_pkg::mac_ctrl_t     mac,
    output logic [((((DATA_WIDTH + mva_pkg::DIG_W - 1) / mva_pkg::DIG_W) > 1) ?
                   $clog2((DATA_WIDTH + mva_pkg::DIG_W - 1) / mva_pkg::DIG_W) : 1) - 1:0]
                                   digit,
    output mva_pkg::emit_t         emit
);

    localparam int NDIG = (DATA_WIDTH + mva_pkg::DIG_W - 1) / mva_pkg::DIG_W;
    localparam int DGW  = (NDIG > 1) ? $clog2(NDIG) : 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_MUL  = 4'b0100,
        S_ACC  = 4'b1000
    } state_t;

    state_t          state_reg, state_next;
    mva_pkg::mode_t  op_reg, op_next;
    logic [1:0]      row_reg, row_next;
    logic [1:0]      col_reg, col_next;
    logic [1:0]      term_reg, term_next;
    logic [DGW-1:0]  digit_reg, digit_next;
    logic            matrix_op;
    logic            res_last;
    logic [1:0]      cross_p;
    logic [1:0]      cross_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= mva_pkg::MODE_LOAD_A;
            row_reg   <= '0;
            col_reg   <= '0;
            term_reg  <= '0;
            digit_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            term_reg  <= term_next;
            digit_reg <= digit_next;
        end
    end

    always_comb
    begin
        matrix_op = (op_reg == mva_pkg::MODE_MAT_ADD) || (op_reg == mva_pkg::MODE_MAT_MUL);
        if (op_reg == mva_pkg::MODE_DOT)
        begin
            res_last = 1'b1;
        end
        else if (matrix_op)
        begin
            res_last = (row_reg == 2'd2) && (col_reg == 2'd2);
        end
        else
        begin
            res_last = (col_reg == 2'd2);
        end
    end

    always_comb
    begin
        // Read addresses and operand routing for the current product term.
        cross_p = (term_reg == 2'd0) ? mva_pkg::next3(col_reg)
                                     : mva_pkg::next3(mva_pkg::next3(col_reg));
        cross_q = (term_reg == 2'd0) ? mva_pkg::next3(mva_pkg::next3(col_reg))
                                     : mva_pkg::next3(col_reg);
        mem.a_raddr0 = '0;
        mem.a_raddr1 = '0;
        mem.b_raddr  = '0;
        mac.p_sel_b  = 1'b0;
        mac.q_sel    = mva_pkg::Q_B;
        case (op_reg)
            mva_pkg::MODE_MAT_ADD, mva_pkg::MODE_VEC_ADD:
            begin
                mem.a_raddr0 = mva_pkg::elem_addr(row_reg, col_reg);
                mem.b_raddr  = mva_pkg::elem_addr(row_reg, col_reg);
                mac.p_sel_b  = (term_reg == 2'd1);
                mac.q_sel    = mva_pkg::Q_ONE;
            end
            mva_pkg::MODE_MAT_MUL:
            begin
                mem.a_raddr0 = mva_pkg::elem_addr(row_reg, term_reg);
                mem.b_raddr  = mva_pkg::elem_addr(term_reg, col_reg);
            end
            mva_pkg::MODE_MAT_VEC:
            begin
                mem.a_raddr0 = mva_pkg::elem_addr(col_reg, term_reg);
                mem.a_raddr1 = mva_pkg::elem_addr(2'd0, term_reg);
                mac.q_sel    = mva_pkg::Q_A1;
            end
            mva_pkg::MODE_DOT:
            begin
                mem.a_raddr0 = mva_pkg::elem_addr(2'd0, term_reg);
                mem.b_raddr  = mva_pkg::elem_addr(2'd0, term_reg);
            end
            mva_pkg::MODE_CROSS:
            begin
                mem.a_raddr0 = mva_pkg::elem_addr(2'd0, cross_p);
                mem.b_raddr  = mva_pkg::elem_addr(2'd0, cross_q);
            end
            default:
            begin
                mem.a_raddr0 = '0;
            end
        endcase

        state_next = state_reg;
        op_next    = op_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        term_next  = term_reg;
        digit_next = digit_reg;
        mem.a_we   = 1'b0;
        mem.b_we   = 1'b0;
        mem.waddr  = mva_pkg::elem_addr(cmd.row_index, cmd.col_index);
        mem.re     = 1'b0;
        mac.mul_en = 1'b0;
        mac.acc_en = 1'b0;
        mac.first  = (term_reg == 2'd0) && (digit_reg == '0);
        mac.negate = (op_reg == mva_pkg::MODE_CROSS) && (term_reg == 2'd1);
        emit.valid = 1'b0;
        emit.row   = row_reg;
        emit.col   = col_reg;
        emit.last  = res_last;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (cmd.mode == mva_pkg::MODE_LOAD_A || cmd.mode == mva_pkg::MODE_LOAD_B)
                    begin
                        if (cmd.row_index != 2'd3 && cmd.col_index != 2'd3)
                        begin
                            mem.a_we = (cmd.mode == mva_pkg::MODE_LOAD_A);
                            mem.b_we = (cmd.mode == mva_pkg::MODE_LOAD_B);
                        end
                    end
                    else
                    begin
                        op_next    = cmd.mode;
                        row_next   = '0;
                        col_next   = '0;
                        term_next  = '0;
                        digit_next = '0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                mem.re     = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                mac.mul_en = 1'b1;
                state_next = S_ACC;
            end
            S_ACC:
            begin
                mac.acc_en = 1'b1;
                if (digit_reg != DGW'(NDIG - 1))
                begin
                    digit_next = DGW'(digit_reg + 1'b1);
                    state_next = S_MUL;
                end
                else
                begin
                    digit_next = '0;
                    if (term_reg != mva_pkg::last_term(op_reg))
                    begin
                        term_next  = term_reg + 2'd1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        term_next  = '0;
                        emit.valid = 1'b1;
                        if (res_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            if (matrix_op && col_reg == 2'd2)
                            begin
                                col_next = '0;
                                row_next = row_reg + 2'd1;
                            end
                            else
                            begin
                                col_next = col_reg + 2'd1;
                            end
                            state_next = S_READ;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy  = (state_reg != S_IDLE);
    assign digit = digit_reg;

    // The final result of a run always hands control back to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (emit.valid && emit.last) |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after the final result");

    // The stores are never written while an operation is reading them.
    assert property (@(posedge clk) disable iff (!rst_n)
        (mem.a_we || mem.b_we) |-> (state_reg == S_IDLE))
        else $error("store write during an operation");

    assert property (@(posedge clk) disable iff (!rst_n)
        (digit_reg <= DGW'(NDIG - 1)) && (term_reg != 2'd3))
        else $error("digit or term counter out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        (row_reg != 2'd3) && (col_reg != 2'd3))
        else $error("result position out of range");

    // Every read is followed by a multiply step on the data it fetched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |=> (state_reg == S_MUL))
        else $error("read not followed by a multiply step");

endmodule

### rtl/matrix_vector_arith_3x3.sv
// Loads are taken only while idle, with busy low, so they run one per cycle between operations.
// An operation holds busy until its final result. Each result takes K product terms (2 for adds
// and cross, 3 otherwise): per term one store read, then a multiply and an accumulate step for
// each of D = ceil(DATA_WIDTH/16) digits. Each result is strobed for one cycle; the receiver
// cannot stall. The pace is set by the single shared multiplier and one store read per term.
// Reset clears the sequencer and the strobe; the matrix stores are undefined until loaded.
module matrix_vector_arith_3x3 #(
    parameter int DATA_WIDTH = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  mva_pkg::cmd_t  cmd,
    output logic           strobe,
    output mva_pkg::res_t  result
);

    // Digits per operand; the sequencer and datapath derive the same figure.
    localparam int NDIG = (DATA_WIDTH + mva_pkg::DIG_W - 1) / mva_pkg::DIG_W;
    localparam int DGW  = (NDIG > 1) ? $clog2(NDIG) : 1;

    mva_pkg::mem_ctrl_t           mem;
    mva_pkg::mac_ctrl_t           mac;
    mva_pkg::emit_t               emit;
    logic [DGW-1:0]               digit;
    logic [DATA_WIDTH-1:0]        wdata;
    logic [1:0][DATA_WIDTH-1:0]   a_rd;
    logic [0:0][DATA_WIDTH-1:0]   b_rd;
    logic [DATA_WIDTH-1:0]        sum;
    logic                         strobe_reg;
    mva_pkg::res_t                result_reg;

    // A loaded element is wrapped to the data width on the way into a store,
    // so every later sum and product works on DATA_WIDTH-bit two's complement.
    assign wdata = DATA_WIDTH'($signed(cmd.element_value));

    // The sequencer owns all control: it accepts transfers, steers the stores
    // and walks the product terms of each result through the shared datapath.
    mva_seq #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .busy  (busy),
        .mem   (mem),
        .mac   (mac),
        .digit (digit),
        .emit  (emit)
    );

    // Store A has two read ports, because the matrix-vector product needs an
    // element of A and an element of row 0 of A for the same term.
    mva_mem #(
        .W        (DATA_WIDTH),
        .RD_PORTS (2)
    ) u_mem_a (
        .clk   (clk),
        .we    (mem.a_we),
        .waddr (mem.waddr),
        .wdata (wdata),
        .re    (mem.re),
        .raddr ({mem.a_raddr1, mem.a_raddr0}),
        .rdata (a_rd)
    );

    mva_mem #(
        .W        (DATA_WIDTH),
        .RD_PORTS (1)
    ) u_mem_b (
        .clk   (clk),
        .we    (mem.b_we),
        .waddr (mem.waddr),
        .wdata (wdata),
        .re    (mem.re),
        .raddr (mem.b_raddr),
        .rdata (b_rd)
    );

    // Additions pass through the same datapath as products with a unit
    // multiplier, which keeps one path for every operation.
    mva_mac #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mac (
        .clk   (clk),
        .ctrl  (mac),
        .digit (digit),
        .a_rd0 (a_rd[0]),
        .a_rd1 (a_rd[1]),
        .b_rd  (b_rd[0]),
        .sum   (sum)
    );

    // Output register: the finished sum is captured in the cycle of its last
    // accumulate and shown for exactly one cycle. As this register stands apart
    // from the sequencer, a new command may be taken while the final result of
    // the previous run is still on the result ports.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= emit.valid;
        end
    end

    // The sum is sign-extended or truncated to the 32-bit result field.
    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            result_reg.result_value <= mva_pkg::FIELD_W'($signed(sum));
            result_reg.out_row      <= emit.row;
            result_reg.out_col      <= emit.col;
            result_reg.last_result  <= emit.last;
        end
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
